/* rtl/core/sorted_integer_set_lookup_core_macros.svh */
// Assertion macros for the sorted integer set lookup core.
`ifndef SORTED_INTEGER_SET_LOOKUP_CORE_MACROS_SVH
`define SORTED_INTEGER_SET_LOOKUP_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SISL_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SISL_ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/sisl_pkg.sv */
// Package with widths, command codes and status codes of the set lookup core.
package sisl_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned SET_DEPTH = 256;

  localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_NOSET = 2'd3;

endpackage

/* rtl/core/sisl_if.sv */
// Valid/ready channel interfaces for commands and results of the set lookup core.
interface sisl_req_if;
  logic                                valid;
  logic                                ready;
  logic [sisl_pkg::CMD_W-1:0]          cmd;
  logic signed [sisl_pkg::DATA_W-1:0]  value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface sisl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sisl_pkg::ST_W-1:0]   status;

  modport source (output valid, found, status, input ready);
  modport sink   (input valid, found, status, output ready);
endinterface

/* rtl/core/sisl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sisl_ram #(
  parameter int unsigned Width = sisl_pkg::DATA_W,
  parameter int unsigned Depth = sisl_pkg::SET_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sorted_integer_set_lookup_core.sv */
// Sorted integer set with binary-search membership and in-place sorted insert.
//
// Usage: commands arrive on req_i (cmd, value) and each produces exactly one
// result on rsp_o (found, status); both are valid/ready channels and a
// transfer happens when valid and ready are high at a rising edge.
// Begin starts an empty valid set, append inserts value at its sorted place,
// query reports membership. A duplicate append or an append into a full set
// invalidates the set; append or query on an invalid set reports no valid set.
// Timing: one command at a time. Begin, the unused code and commands without a
// valid set go straight to the result. A query makes P search probes (at most
// ceil(log2(count+1)), 9 for a full set of 256), each probe being one read of
// the element RAM and one compare with the command value. An append also moves
// the M entries above the insert point up one place, each read and written back
// through the single RAM port pair, before it writes the new value.
// req_i.ready is high only while no command is in work, so the next command
// can transfer in the same cycle the result turns valid; a finished result waits in
// the output register while the next command is taken, and the core holds a
// later result until rsp_o is drained.
// Reset empties the output register and leaves no valid set; the RAM needs no
// clearing since only entries below the element count are read.
module sorted_integer_set_lookup_core #(
  parameter int unsigned SetDepth = sisl_pkg::SET_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sisl_req_if.sink     req_i,
  sisl_rsp_if.source   rsp_o
);

  `include "sorted_integer_set_lookup_core_macros.svh"

  localparam int unsigned AddrW = $clog2(SetDepth);
  localparam int unsigned CntW  = $clog2(SetDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(SetDepth);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PROBE  = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SHR    = 3'd4;
  localparam logic [2:0] S_SHW    = 3'd5;
  localparam logic [2:0] S_INS    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                         state_q, state_d;
  logic [CntW-1:0]                    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               hit_q, hit_d;
  logic                               set_valid_q, set_valid_d;
  logic [sisl_pkg::CMD_W-1:0]         cmd_q, cmd_d;
  logic signed [sisl_pkg::DATA_W-1:0] value_q, value_d;
  logic                               res_found_q, res_found_d;
  logic [sisl_pkg::ST_W-1:0]          res_status_q, res_status_d;
  logic                               out_vq, out_vd;
  logic                               out_found_q, out_found_d;
  logic [sisl_pkg::ST_W-1:0]          out_status_q, out_status_d;

  logic [CntW-1:0]                    span, mid, hi_m1;
  logic                               ram_we, ram_re;
  logic [AddrW-1:0]                   ram_waddr, ram_raddr;
  logic [sisl_pkg::DATA_W-1:0]        ram_wdata, ram_rdata;
  logic                               req_xfer, out_free;

  assign span     = hi_q - lo_q;
  assign mid      = lo_q + (span >> 1);
  assign hi_m1    = hi_q - 1'b1;
  assign req_xfer = req_i.valid && req_i.ready;
  assign out_free = !out_vq || rsp_o.ready;

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = out_vq;
  assign rsp_o.found  = out_found_q;
  assign rsp_o.status = out_status_q;

  sisl_ram #(
    .Width (sisl_pkg::DATA_W),
    .Depth (SetDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    count_d      = count_q;
    hit_d        = hit_q;
    set_valid_d  = set_valid_q;
    cmd_d        = cmd_q;
    value_d      = value_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_vd       = out_vq && !rsp_o.ready;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = lo_q[AddrW-1:0];
    ram_raddr    = mid[AddrW-1:0];
    ram_wdata    = value_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          cmd_d        = req_i.cmd;
          value_d      = req_i.value;
          res_found_d  = 1'b0;
          res_status_d = sisl_pkg::ST_OK;
          lo_d         = '0;
          hi_d         = count_q;
          hit_d        = 1'b0;
          state_d      = S_DONE;
          unique case (req_i.cmd) inside
            sisl_pkg::CMD_BEGIN: begin
              count_d     = '0;
              set_valid_d = 1'b1;
            end
            sisl_pkg::CMD_APPEND, sisl_pkg::CMD_QUERY: begin
              if (set_valid_q) begin
                state_d = S_PROBE;
              end else begin
                res_status_d = sisl_pkg::ST_NOSET;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          ram_re  = 1'b1;
          mid_d   = mid;
          state_d = S_CMP;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_CMP: begin
        if ($signed(ram_rdata) < value_q) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        if ($signed(ram_rdata) == value_q) begin
          hit_d = 1'b1;
        end
        state_d = S_PROBE;
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (cmd_q == sisl_pkg::CMD_QUERY) begin
          res_found_d = hit_q;
        end else if (hit_q) begin
          set_valid_d  = 1'b0;
          res_status_d = sisl_pkg::ST_DUP;
        end else if (count_q >= DepthCnt) begin
          set_valid_d  = 1'b0;
          res_status_d = sisl_pkg::ST_FULL;
        end else begin
          hi_d    = count_q;
          state_d = (count_q > lo_q) ? S_SHR : S_INS;
        end
      end
      S_SHR: begin
        ram_re    = 1'b1;
        ram_raddr = hi_m1[AddrW-1:0];
        state_d   = S_SHW;
      end
      S_SHW: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q[AddrW-1:0];
        ram_wdata = ram_rdata;
        hi_d      = hi_m1;
        state_d   = (hi_m1 > lo_q) ? S_SHR : S_INS;
      end
      S_INS: begin
        ram_we  = 1'b1;
        count_d = count_q + 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_vd       = 1'b1;
          out_found_d  = res_found_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      set_valid_q <= 1'b0;
      out_vq      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      set_valid_q <= set_valid_d;
      out_vq      <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    hit_q        <= hit_d;
    cmd_q        <= cmd_d;
    value_q      <= value_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
  end

  `SISL_ASSERT_RST(a_busy_after_xfer, clk_i, rst_ni, req_xfer |=> !req_i.ready, "core took a command while busy")
  `SISL_ASSERT_RST(a_count_step, clk_i, rst_ni, (count_q != $past(count_q)) |-> ((count_q == '0) || (count_q == $past(count_q) + 1'b1)), "element count moved by more than one insert")
  `SISL_ASSERT_CLK(a_count_bound, clk_i, count_q <= DepthCnt, "element count beyond capacity")
  `SISL_ASSERT_RST(a_found_ok, clk_i, rst_ni, (out_vq && out_found_q) |-> (out_status_q == sisl_pkg::ST_OK), "found reported with error status")

endmodule

/* sim/sorted_integer_set_lookup_core_tb.sv */
// Self-checking testbench for the sorted integer set lookup core.
module sorted_integer_set_lookup_core_tb;

  localparam logic [sisl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [sisl_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sisl_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_ITEMS    = 1250;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic [sisl_pkg::CMD_W-1:0]          cmd;
    logic signed [sisl_pkg::DATA_W-1:0]  value;
  } set_cmd_t;

  typedef struct {
    logic                       found;
    logic [sisl_pkg::ST_W-1:0]  status;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  sisl_req_if req_if ();
  sisl_rsp_if rsp_if ();

  sorted_integer_set_lookup_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // Predicted set contents, kept in ascending order.
  logic signed [sisl_pkg::DATA_W-1:0] set_mem [sisl_pkg::SET_DEPTH];
  int                                 set_count;
  bit                                 set_live;

  set_cmd_t                           cmd_pending [$];
  set_result_t                        result_expected [$];
  logic signed [sisl_pkg::DATA_W-1:0] built_vals [$];

  int n_total;
  int n_accepted;
  int n_checked;
  int n_hits;
  int n_mismatch;
  int st_seen [4];
  int stall_left;
  int stalls_done;
  int idle_cycles;
  bit stuck;
  set_result_t want;

  function automatic int set_lower_bound(input logic signed [sisl_pkg::DATA_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = set_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (set_mem[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic set_result_t set_apply(input logic [sisl_pkg::CMD_W-1:0] c,
                                            input logic signed [sisl_pkg::DATA_W-1:0] v);
    set_result_t r;
    int pos;
    r.found  = 1'b0;
    r.status = sisl_pkg::ST_OK;
    case (c)
      sisl_pkg::CMD_BEGIN: begin
        set_count = 0;
        set_live  = 1'b1;
      end
      sisl_pkg::CMD_APPEND: begin
        if (!set_live) begin
          r.status = sisl_pkg::ST_NOSET;
        end else begin
          pos = set_lower_bound(v);
          if (pos < set_count && set_mem[pos] == v) begin
            set_live = 1'b0;
            r.status = sisl_pkg::ST_DUP;
          end else if (set_count >= sisl_pkg::SET_DEPTH) begin
            set_live = 1'b0;
            r.status = sisl_pkg::ST_FULL;
          end else begin
            for (int i = set_count; i > pos; i--) set_mem[i] = set_mem[i-1];
            set_mem[pos] = v;
            set_count++;
          end
        end
      end
      sisl_pkg::CMD_QUERY: begin
        if (!set_live) begin
          r.status = sisl_pkg::ST_NOSET;
        end else begin
          pos = set_lower_bound(v);
          if (pos < set_count && set_mem[pos] == v) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int idle_share(input bit sender_side);
    int phase;
    phase = (n_total > 0) ? (n_accepted * 3) / n_total : 0;
    case (phase)
      0:       return sender_side ? 14 : 73;
      1:       return sender_side ? 73 : 14;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [sisl_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $urandom_range(0, 1000) - 500;
      7: begin
        case ($urandom_range(5))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return '0;
          3:       return -1;
          4:       return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
      8:       return VAL_MIN + $urandom_range(0, 64);
      default: return VAL_MAX - $urandom_range(0, 64);
    endcase
  endfunction

  function automatic logic signed [sisl_pkg::DATA_W-1:0] pick_member();
    if (built_vals.size() > 0 && $urandom_range(1) == 0)
      return built_vals[$urandom_range(built_vals.size() - 1)];
    return pick_value();
  endfunction

  task automatic queue_cmd(input logic [sisl_pkg::CMD_W-1:0] c,
                           input logic signed [sisl_pkg::DATA_W-1:0] v);
    cmd_pending.push_back('{cmd: c, value: v});
  endtask

  task automatic queue_append(input logic signed [sisl_pkg::DATA_W-1:0] v);
    queue_cmd(sisl_pkg::CMD_APPEND, v);
    built_vals.push_back(v);
  endtask

  task automatic queue_full_fill(input bit descending, input bit end_with_dup);
    longint base;
    longint step;
    logic signed [sisl_pkg::DATA_W-1:0] v;
    step = $urandom_range(1, 8000000);
    base = descending ? (64'sd2147483647 - $urandom_range(0, 1000))
                      : (-64'sd2147483648 + $urandom_range(0, 1000));
    queue_cmd(sisl_pkg::CMD_BEGIN, $urandom());
    built_vals.delete();
    for (int i = 0; i < sisl_pkg::SET_DEPTH; i++) begin
      v = 32'(descending ? base - i * step : base + i * step);
      queue_append(v);
      if (i % 16 == 15) queue_cmd(sisl_pkg::CMD_QUERY, pick_member());
    end
    v = 32'(descending ? base - sisl_pkg::SET_DEPTH * step
                       : base + sisl_pkg::SET_DEPTH * step);
    queue_cmd(sisl_pkg::CMD_QUERY, v);
    queue_cmd(sisl_pkg::CMD_QUERY, built_vals[$urandom_range(sisl_pkg::SET_DEPTH - 1)]);
    queue_cmd(sisl_pkg::CMD_APPEND,
              end_with_dup ? built_vals[$urandom_range(sisl_pkg::SET_DEPTH - 1)] : v);
    queue_cmd(sisl_pkg::CMD_QUERY, built_vals[0]);
    queue_cmd(sisl_pkg::CMD_APPEND, v);
  endtask

  task automatic queue_small_set();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
    queue_cmd(sisl_pkg::CMD_BEGIN, pick_value());
    built_vals.delete();
    repeat (n) begin
      if ($urandom_range(9) < 7) queue_append(pick_value());
      else queue_cmd(sisl_pkg::CMD_QUERY, pick_member());
    end
    if ($urandom_range(5) == 0 && built_vals.size() > 0)
      queue_cmd(sisl_pkg::CMD_APPEND, built_vals[$urandom_range(built_vals.size() - 1)]);
    repeat ($urandom_range(2, 6)) queue_cmd(sisl_pkg::CMD_QUERY, pick_member());
    if ($urandom_range(7) == 0) queue_cmd(sisl_pkg::CMD_APPEND, pick_value());
  endtask

  task automatic queue_noise();
    repeat (5) queue_cmd(2'($urandom_range(3)), pick_value());
  endtask

  task automatic flag_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) $display("%s", what);
  endtask

  // Driver: present the next pending command once the current one has transferred.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.cmd   <= sisl_pkg::CMD_BEGIN;
      req_if.value <= '0;
      n_accepted   <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        result_expected.push_back(set_apply(req_if.cmd, req_if.value));
        n_accepted <= n_accepted + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (cmd_pending.size() > 0 && $urandom_range(99) >= idle_share(1'b1)) begin
          req_if.valid <= 1'b1;
          req_if.cmd   <= cmd_pending[0].cmd;
          req_if.value <= cmd_pending[0].value;
          void'(cmd_pending.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus two long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      stalls_done  <= 0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if ((stalls_done == 0 && n_accepted >= 200) ||
                 (stalls_done == 1 && n_accepted >= (n_total * 5) / 6)) begin
      stall_left   <= HOLD_CYCLES;
      stalls_done  <= stalls_done + 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= idle_share(1'b0));
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (result_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: found=%0b status=%0d",
                                rsp_if.found, rsp_if.status));
      end else begin
        want = result_expected.pop_front();
        n_checked++;
        if (want.found) n_hits++;
        st_seen[want.status]++;
        if (rsp_if.found !== want.found || rsp_if.status !== want.status)
          flag_mismatch($sformatf("result %0d: expected found=%0b status=%0d, got found=%0b status=%0d",
                                  n_checked, want.found, want.status,
                                  rsp_if.found, rsp_if.status));
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
      stuck       <= 1'b0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      stuck <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int start;
    bit desc_filled;
    rst_ni <= 1'b0;
    set_count = 0;
    set_live  = 1'b0;
    desc_filled = 1'b0;
    foreach (st_seen[i]) st_seen[i] = 0;

    queue_cmd(sisl_pkg::CMD_QUERY, 32'sd5);
    queue_cmd(sisl_pkg::CMD_APPEND, 32'sd7);
    queue_cmd(CMD_UNUSED, -1);
    queue_cmd(sisl_pkg::CMD_BEGIN, '0);
    queue_cmd(sisl_pkg::CMD_QUERY, '0);
    queue_cmd(sisl_pkg::CMD_APPEND, VAL_MIN);
    queue_cmd(sisl_pkg::CMD_APPEND, VAL_MAX);
    queue_cmd(sisl_pkg::CMD_APPEND, '0);
    queue_cmd(sisl_pkg::CMD_APPEND, -1);
    queue_cmd(sisl_pkg::CMD_APPEND, 32'sd1);
    queue_cmd(sisl_pkg::CMD_QUERY, VAL_MIN);
    queue_cmd(sisl_pkg::CMD_QUERY, VAL_MAX);
    queue_cmd(sisl_pkg::CMD_QUERY, -1);
    queue_cmd(sisl_pkg::CMD_QUERY, 32'sd2);
    queue_cmd(CMD_UNUSED, VAL_MAX);
    queue_cmd(sisl_pkg::CMD_QUERY, '0);
    queue_cmd(sisl_pkg::CMD_APPEND, VAL_MAX);
    queue_cmd(sisl_pkg::CMD_QUERY, VAL_MAX);
    queue_cmd(sisl_pkg::CMD_APPEND, 32'sd5);
    queue_cmd(sisl_pkg::CMD_BEGIN, VAL_MIN);
    queue_cmd(sisl_pkg::CMD_QUERY, VAL_MAX);
    queue_cmd(sisl_pkg::CMD_APPEND, 32'sh5555_5555);
    queue_cmd(sisl_pkg::CMD_APPEND, 32'shAAAA_AAAA);
    queue_cmd(sisl_pkg::CMD_QUERY, 32'shAAAA_AAAA);
    queue_cmd(sisl_pkg::CMD_QUERY, 32'sh5555_5554);

    start = cmd_pending.size();
    queue_full_fill(1'b0, 1'b1);
    while (cmd_pending.size() - start < RANDOM_ITEMS) begin
      if ($urandom_range(4) == 0) queue_noise();
      else queue_small_set();
      if (cmd_pending.size() - start > RANDOM_ITEMS / 2 && !desc_filled) begin
        queue_full_fill(1'b1, 1'b0);
        desc_filled = 1'b1;
      end
    end
    n_total = cmd_pending.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((cmd_pending.size() > 0 || req_if.valid) && !stuck) @(posedge clk_i);
    while (result_expected.size() > 0 && !stuck) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d of %0d commands: %0d hits, %0d duplicate, %0d overflow, %0d no-set",
             n_checked, n_total, n_hits, st_seen[sisl_pkg::ST_DUP],
             st_seen[sisl_pkg::ST_FULL], st_seen[sisl_pkg::ST_NOSET]);
    $display("ran full-depth fills in both orders and %0d long output stalls, %0d mismatches",
             stalls_done, n_mismatch);
    if (!stuck && n_mismatch == 0) begin
      $display("sorted_integer_set_lookup_core_tb passed");
    end else begin
      $display("sorted_integer_set_lookup_core_tb failed");
    end
    $finish;
  end

endmodule

/* sorted_integer_set_lookup_core.f */
+incdir+rtl/core
rtl/core/sisl_pkg.sv
rtl/core/sisl_if.sv
rtl/core/sisl_ram.sv
rtl/core/sorted_integer_set_lookup_core.sv
sim/sorted_integer_set_lookup_core_tb.sv
